// ===== sv/slt_pkg.sv =====
// shared types, constants and decode functions for the tokenizer
`default_nettype none

package slt_pkg;

  localparam int KEYWORD_MAX_LEN = 5;
  localparam int NUMBER_BITS     = 31;
  localparam int LINE_BITS       = 24;
  localparam int KW_BITS         = 8 * KEYWORD_MAX_LEN;
  localparam int LEN_W           = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int KW_COUNT        = 17;
  localparam int KIND_W          = 6;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  // result kinds
  localparam logic [KIND_W-1:0] K_TEXT       = 6'd0;
  localparam logic [KIND_W-1:0] K_END        = 6'd1;
  localparam logic [KIND_W-1:0] K_ERROR      = 6'd2;
  localparam logic [KIND_W-1:0] K_IDENT      = 6'd3;
  localparam logic [KIND_W-1:0] K_NUMBER     = 6'd4;
  localparam logic [KIND_W-1:0] K_STRING     = 6'd5;
  localparam logic [KIND_W-1:0] K_KEYBASE    = 6'd6;
  localparam logic [KIND_W-1:0] K_OP_EQ      = 6'd23;
  localparam logic [KIND_W-1:0] K_OP_LPAREN  = 6'd24;
  localparam logic [KIND_W-1:0] K_OP_RPAREN  = 6'd25;
  localparam logic [KIND_W-1:0] K_OP_PLUS    = 6'd26;
  localparam logic [KIND_W-1:0] K_OP_MINUS   = 6'd27;
  localparam logic [KIND_W-1:0] K_OP_STAR    = 6'd28;
  localparam logic [KIND_W-1:0] K_OP_SLASH   = 6'd29;
  localparam logic [KIND_W-1:0] K_OP_CARET   = 6'd30;
  localparam logic [KIND_W-1:0] K_OP_AMP     = 6'd31;
  localparam logic [KIND_W-1:0] K_OP_BAR     = 6'd32;
  localparam logic [KIND_W-1:0] K_OP_TILDE   = 6'd33;
  localparam logic [KIND_W-1:0] K_OP_HASH    = 6'd34;
  localparam logic [KIND_W-1:0] K_COLON      = 6'd35;
  localparam logic [KIND_W-1:0] K_ASSIGN     = 6'd36;
  localparam logic [KIND_W-1:0] K_NEG        = 6'd37;
  localparam logic [KIND_W-1:0] K_NE         = 6'd38;
  localparam logic [KIND_W-1:0] K_LT         = 6'd39;
  localparam logic [KIND_W-1:0] K_LTE        = 6'd40;
  localparam logic [KIND_W-1:0] K_SHL        = 6'd41;
  localparam logic [KIND_W-1:0] K_GT         = 6'd42;
  localparam logic [KIND_W-1:0] K_GTE        = 6'd43;
  localparam logic [KIND_W-1:0] K_SHR        = 6'd44;

  // characters
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // keywords, packed right-justified, in kind order
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "decat", "die", "drop", "dup", "end", "if", "incat", "leave", "nop",
    "out", "outc", "over", "peek", "rot", "st", "swap", "while"
  };
  localparam int KW_LEN [KW_COUNT] = '{5, 3, 4, 3, 3, 2, 5, 5, 3, 3, 4, 4, 4, 3, 2, 4, 5};

  typedef enum logic [3:0] {
    ST_START,
    ST_WORD,
    ST_NUM,
    ST_COLON,
    ST_LT,
    ST_GT,
    ST_EXCL,
    ST_COMMENT,
    ST_STR
  } scan_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [7:0]             text_char;
    logic [NUMBER_BITS-1:0] number_value;
    logic [LINE_BITS-1:0]   line_number;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [7:0]        text;
    scan_state_t       nstate;
    logic              load_num;
    logic              load_word;
    logic              clr_esc;
  } start_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic [KIND_W-1:0] word_kind(input logic [KW_BITS-1:0] prefix,
                                                   input logic [LEN_W-1:0]   len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((KW_TEXT[i] == prefix) && (LEN_W'(KW_LEN[i]) == len)) begin
        k = K_KEYBASE + KIND_W'(i);
      end
    end
    return k;
  endfunction

  function automatic start_t start_char(input logic [7:0] c, input logic eof);
    start_t s;
    s = '0;
    s.nstate = ST_START;
    if (eof) begin
      s.emit = 1'b1;
      s.kind = K_END;
    end else if (is_digit(c)) begin
      s.nstate   = ST_NUM;
      s.load_num = 1'b1;
    end else if (is_alpha(c)) begin
      s.nstate    = ST_WORD;
      s.load_word = 1'b1;
      s.emit      = 1'b1;
      s.kind      = K_TEXT;
      s.text      = c;
    end else begin
      case (c)
        CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR: begin
          s.emit = 1'b0;
        end
        CH_COLON: s.nstate = ST_COLON;
        CH_EXCL:  s.nstate = ST_EXCL;
        CH_LT:    s.nstate = ST_LT;
        CH_GT:    s.nstate = ST_GT;
        CH_QUOTE: begin
          s.nstate  = ST_STR;
          s.clr_esc = 1'b1;
        end
        CH_SEMI:   s.nstate = ST_COMMENT;
        CH_EQ:     begin s.emit = 1'b1; s.kind = K_OP_EQ;     end
        CH_LPAREN: begin s.emit = 1'b1; s.kind = K_OP_LPAREN; end
        CH_RPAREN: begin s.emit = 1'b1; s.kind = K_OP_RPAREN; end
        CH_PLUS:   begin s.emit = 1'b1; s.kind = K_OP_PLUS;   end
        CH_MINUS:  begin s.emit = 1'b1; s.kind = K_OP_MINUS;  end
        CH_STAR:   begin s.emit = 1'b1; s.kind = K_OP_STAR;   end
        CH_SLASH:  begin s.emit = 1'b1; s.kind = K_OP_SLASH;  end
        CH_CARET:  begin s.emit = 1'b1; s.kind = K_OP_CARET;  end
        CH_AMP:    begin s.emit = 1'b1; s.kind = K_OP_AMP;    end
        CH_BAR:    begin s.emit = 1'b1; s.kind = K_OP_BAR;    end
        CH_TILDE:  begin s.emit = 1'b1; s.kind = K_OP_TILDE;  end
        CH_HASH:   begin s.emit = 1'b1; s.kind = K_OP_HASH;   end
        default: begin
          s.emit = 1'b1;
          s.kind = K_ERROR;
        end
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/slt_scan.sv =====
// scanner state and per-character token decode, up to two results per step
`default_nettype none

module slt_scan import slt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire logic       at_end,
  output push_t           push
);

  localparam int ACC_W = NUMBER_BITS + 4;
  localparam logic [NUMBER_BITS-1:0] NUM_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  scan_state_t            state_r, state_nxt;
  logic                   esc_r, esc_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic [KW_BITS-1:0]     prefix_r, prefix_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;

  start_t                 st;
  logic [ACC_W-1:0]       acc_ext;
  logic [ACC_W-1:0]       acc_x10;
  logic                   acc_sat;
  logic                   eq;

  logic                   f_emit;
  logic [KIND_W-1:0]      f_kind;
  logic [7:0]             f_text;
  logic [NUMBER_BITS-1:0] f_num;
  logic                   redo;
  logic                   use_start;

  logic                   a_emit;
  logic                   b_emit;
  res_t                   res_a;
  res_t                   res_b;

  assign st      = start_char(ch, at_end);
  assign eq      = !at_end && (ch == CH_EQ);
  assign acc_ext = ACC_W'(acc_r);
  assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(ch[3:0]);
  assign acc_sat = acc_x10 > ACC_W'(NUM_MAX);

  always_comb begin
    state_nxt  = state_r;
    esc_nxt    = esc_r;
    acc_nxt    = acc_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    f_emit     = 1'b0;
    f_kind     = K_TEXT;
    f_text     = '0;
    f_num      = '0;
    redo       = 1'b0;
    use_start  = 1'b0;
    case (state_r)
      ST_START: use_start = 1'b1;
      ST_COLON: begin
        f_emit    = 1'b1;
        f_kind    = eq ? K_ASSIGN : K_COLON;
        state_nxt = ST_START;
        redo      = !eq;
      end
      ST_EXCL: begin
        f_emit    = 1'b1;
        f_kind    = eq ? K_NE : K_NEG;
        state_nxt = ST_START;
        redo      = !eq;
      end
      ST_LT: begin
        f_emit    = 1'b1;
        state_nxt = ST_START;
        if (eq) begin
          f_kind = K_LTE;
        end else if (!at_end && (ch == CH_LT)) begin
          f_kind = K_SHL;
        end else begin
          f_kind = K_LT;
          redo   = 1'b1;
        end
      end
      ST_GT: begin
        f_emit    = 1'b1;
        state_nxt = ST_START;
        if (eq) begin
          f_kind = K_GTE;
        end else if (!at_end && (ch == CH_GT)) begin
          f_kind = K_SHR;
        end else begin
          f_kind = K_GT;
          redo   = 1'b1;
        end
      end
      ST_WORD: begin
        f_emit = 1'b1;
        if (!at_end && is_alpha(ch)) begin
          f_kind = K_TEXT;
          f_text = ch;
          if (len_r < LEN_W'(KEYWORD_MAX_LEN)) begin
            prefix_nxt = {prefix_r[KW_BITS-9:0], ch};
            len_nxt    = len_r + 1'b1;
          end else begin
            len_nxt = LEN_W'(KEYWORD_MAX_LEN + 1);
          end
        end else begin
          f_kind    = word_kind(prefix_r, len_r);
          state_nxt = ST_START;
          redo      = 1'b1;
        end
      end
      ST_NUM: begin
        if (!at_end && is_digit(ch)) begin
          acc_nxt = acc_sat ? NUM_MAX : acc_x10[NUMBER_BITS-1:0];
        end else begin
          f_emit    = 1'b1;
          f_kind    = K_NUMBER;
          f_num     = acc_r;
          state_nxt = ST_START;
          redo      = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (at_end) begin
          state_nxt = ST_START;
          redo      = 1'b1;
        end else if (ch == CH_LF) begin
          state_nxt = ST_START;
        end
      end
      ST_STR: begin
        if (at_end) begin
          f_emit    = 1'b1;
          f_kind    = K_ERROR;
          esc_nxt   = 1'b0;
          state_nxt = ST_START;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          f_emit  = 1'b1;
          f_kind  = K_TEXT;
          f_text  = ch;
        end else if (ch == CH_BSL) begin
          esc_nxt = 1'b1;
        end else if (ch == CH_QUOTE) begin
          f_emit    = 1'b1;
          f_kind    = K_STRING;
          state_nxt = ST_START;
        end else begin
          f_emit = 1'b1;
          f_kind = K_TEXT;
          f_text = ch;
        end
      end
      default: use_start = 1'b1;
    endcase

    // character handled from the start state, first or again
    if (use_start || redo) begin
      state_nxt = st.nstate;
      if (st.load_num) begin
        acc_nxt = NUMBER_BITS'(ch[3:0]);
      end
      if (st.load_word) begin
        prefix_nxt = KW_BITS'(ch);
        len_nxt    = LEN_W'(1);
      end
      if (st.clr_esc) begin
        esc_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    a_emit = use_start ? st.emit : f_emit;
    b_emit = redo && st.emit;

    res_a.kind         = use_start ? st.kind : f_kind;
    res_a.text_char    = use_start ? st.text : f_text;
    res_a.number_value = use_start ? '0 : f_num;
    res_a.line_number  = line_r;
    res_a.last         = !b_emit;

    res_b.kind         = st.kind;
    res_b.text_char    = st.text;
    res_b.number_value = '0;
    res_b.line_number  = line_r;
    res_b.last         = 1'b1;

    push.r0  = a_emit ? res_a : res_b;
    push.r1  = res_b;
    push.cnt = step ? {a_emit && b_emit, a_emit ^ b_emit} : 2'd0;
  end

  assign line_nxt = (!at_end && (ch == CH_LF) && (line_r != LINE_MAX)) ?
                    line_r + 1'b1 : line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      esc_r    <= 1'b0;
      acc_r    <= '0;
      prefix_r <= '0;
      len_r    <= '0;
      line_r   <= '0;
    end else if (step) begin
      state_r  <= state_nxt;
      esc_r    <= esc_nxt;
      acc_r    <= acc_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/slt_result_fifo.sv =====
// small result queue: up to two writes and one read per cycle
`default_nettype none

module slt_result_fifo import slt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output logic       head_valid,
  output logic       room
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign head_valid = cnt_r != '0;
  assign room       = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stack_language_tokenizer_core.sv =====
// top level of the stack-language tokenizer
//
// input channel: one source character (in_ch) or an end-of-input mark
// (in_at_end) per transaction, taken when in_valid is high and in_stall low.
// result channel: text characters and tokens in source order, each with the
// newline count seen before its character; out_last marks the final result
// of one input character.
// an accepted character is held in the input register, decoded combinationally
// by the scanner and written to a four-entry result queue, from whose head its
// first result is offered.
// one character is taken per cycle while the queue has room for two more
// results; the output port drains one result per cycle while out_stall is low,
// so the sustained rate is one character per cycle while characters yield at
// most one result each.
// when out_stall is high the queue holds its head and fills; once fewer than
// two slots are free in_stall rises, while a character is held, until results are taken.
// reset clears the scanner to its start state, the line count to zero and
// empties the queue.
`default_nettype none

module stack_language_tokenizer_core import slt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_ch,
  input  wire logic                   in_at_end,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [KIND_W-1:0]           out_kind,
  output logic [7:0]                  out_text_char,
  output logic [NUMBER_BITS-1:0]      out_number_value,
  output logic [LINE_BITS-1:0]        out_line_number,
  output logic                        out_last
);

  logic       hold_valid_r;
  logic [7:0] ch_r;
  logic       at_end_r;
  logic       room;
  logic       step;
  logic       in_fire;
  logic       pop;
  push_t      push;
  res_t       head;

  assign step     = hold_valid_r && room;
  assign in_stall = hold_valid_r && !room;
  assign in_fire  = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_fire) begin
      hold_valid_r <= 1'b1;
    end else if (step) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r     <= in_ch;
      at_end_r <= in_at_end;
    end
  end

  slt_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ch     (ch_r),
    .at_end (at_end_r),
    .push   (push)
  );

  slt_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .room       (room)
  );

  assign out_kind         = head.kind;
  assign out_text_char    = head.text_char;
  assign out_number_value = head.number_value;
  assign out_line_number  = head.line_number;
  assign out_last         = head.last;

  a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.r0.last && push.r1.last)
    else $error("two-result step has wrong last flags");

  a_one_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd1 |-> push.r0.last)
    else $error("single result not marked last");

  a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> step)
    else $error("results written without a scan step");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

`default_nettype wire
